[rtl/icfm_pkg.sv]
// Shared types, field widths and codes for the input capture frequency meter.
package icfm_pkg;

  localparam int ICFM_COUNTER_BITS = 16;
  localparam int CAP_W  = 16;
  localparam int BUS_W  = 26;
  localparam int PRE_W  = 17;
  localparam int PER_W  = 17;
  localparam int FREQ_W = 42;
  localparam int FRAC_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 26;

  localparam logic [BUS_W-1:0] BUS_CLOCK_RESET = 26'd24000000;
  localparam logic [PRE_W-1:0] PRESCALE_RESET  = 17'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_BUS_CLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 1'd1;

  localparam logic [1:0] STS_STORED = 2'd0;
  localparam logic [1:0] STS_READY  = 2'd1;
  localparam logic [1:0] STS_ERROR  = 2'd2;

  typedef struct packed {
    logic [CAP_W-1:0] capture_value;
    logic             direction_pin;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PER_W-1:0]  period_ticks;
    logic [FREQ_W-1:0] frequency_q16;
    logic              moving_forward;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic start_mul;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic out_busy;
  } dp_sts_t;

endpackage

[rtl/icfm_ctrl.sv]
// Controller state machine that sequences capture, multiply, divide and output load.
module icfm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  icfm_pkg::dp_sts_t sts,
  output icfm_pkg::dp_cmd_t cmd
);
  import icfm_pkg::*;

  localparam int CNT_W = $clog2(FREQ_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FREQ_W - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.needs_div ? S_MUL : S_LOAD;
        end
      end
      S_MUL: begin
        cmd.start_mul = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[rtl/icfm_dp.sv]
// Datapath: configuration, phase state, period multiplier, serial divider and output register.
module icfm_dp #(
  parameter int COUNTER_BITS = icfm_pkg::ICFM_COUNTER_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [icfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  icfm_pkg::in_item_t               in_data,
  input  icfm_pkg::dp_cmd_t                cmd,
  output icfm_pkg::dp_sts_t                sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output icfm_pkg::out_item_t              out_data
);
  import icfm_pkg::*;

  localparam int CW = COUNTER_BITS;
  localparam int DW = CW + PRE_W;

  logic [BUS_W-1:0]  bus_r;
  logic [PRE_W-1:0]  pre_r;
  logic              phase_r;
  logic [CW-1:0]     first_r;
  logic [CW-1:0]     diff_r;
  logic [1:0]        kind_r;
  logic              dir_r;
  logic [DW-1:0]     prod_r;
  logic [DW-1:0]     rem_r;
  logic [FREQ_W-1:0] quo_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [CW+CAP_W-1:0] cap_ext;
  logic [CW-1:0]       cap_m;
  logic [PRE_W-1:0]    pre_eff;
  logic [DW:0]         trial;
  logic                fits;
  logic [CW+PER_W-1:0] per_ext;

  // Captures wider than the counter are masked; narrower ones are zero-extended.
  assign cap_ext = {{CW{1'b0}}, in_data.capture_value};
  assign cap_m   = cap_ext[CW-1:0];
  assign pre_eff = (pre_r == '0) ? PRE_W'(1) : pre_r;
  assign per_ext = {{PER_W{1'b0}}, diff_r};

  assign trial = {rem_r, quo_r[FREQ_W-1]};
  assign fits  = trial >= {1'b0, prod_r};

  assign sts.needs_div = phase_r && (cap_m != first_r);
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r       <= BUS_CLOCK_RESET;
      pre_r       <= PRESCALE_RESET;
      phase_r     <= 1'b0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BUS_CLOCK) begin
          bus_r <= cfg_wdata[BUS_W-1:0];
        end else if (cfg_index == CFG_PRESCALE) begin
          pre_r <= cfg_wdata[PRE_W-1:0];
        end
      end
      if (cmd.accept) begin
        phase_r <= !phase_r;
        if (!phase_r) begin
          first_r <= cap_m;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dir_r  <= in_data.direction_pin;
      diff_r <= cap_m - first_r;
      if (!phase_r) begin
        kind_r <= STS_STORED;
      end else if (cap_m == first_r) begin
        kind_r <= STS_ERROR;
      end else begin
        kind_r <= STS_READY;
      end
    end
    if (cmd.start_mul) begin
      prod_r <= DW'(diff_r) * DW'(pre_eff);
      rem_r  <= '0;
      quo_r  <= {bus_r, {FRAC_W{1'b0}}};
    end
    if (cmd.div_step) begin
      rem_r <= fits ? DW'(trial - {1'b0, prod_r}) : trial[DW-1:0];
      quo_r <= {quo_r[FREQ_W-2:0], fits};
    end
    if (cmd.load_out) begin
      out_r.status         <= kind_r;
      out_r.moving_forward <= dir_r;
      out_r.period_ticks   <= (kind_r == STS_READY) ? per_ext[PER_W-1:0] : '0;
      out_r.frequency_q16  <= (kind_r == STS_READY) ? quo_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/input_capture_frequency_meter_top.sv]
// Top level of the input capture period and frequency meter.
//
// The block takes one timer capture transaction per input edge. Captures alternate: the first
// is stored and answered at once with status "stored", the second yields the tick difference
// modulo 2^COUNTER_BITS and the frequency floor(bus_clock_hz * 65536 / (ticks * prescale)) as
// an unsigned Q26.16 value. Equal captures give an error status and restart the pairing. A
// first capture or an error goes from acceptance straight to the output load; a measurement
// passes through acceptance, a multiply, the one-bit-per-cycle restoring divider and the
// output load. One transaction is in work at a time; the result sits in an output register,
// so the next capture is accepted while an earlier result still waits downstream. A prescale
// of zero acts as one.
module input_capture_frequency_meter_top #(
  parameter int COUNTER_BITS = icfm_pkg::ICFM_COUNTER_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [icfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  icfm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output icfm_pkg::out_item_t              out_data
);
  import icfm_pkg::*;

  // Commands from the controller to the datapath and status flowing back.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  icfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  icfm_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The output register must never be overwritten while its transaction is still pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_out |-> !dp_sts.out_busy)
    else $error("output register loaded while a result was still pending");

  // Only a completed measurement carries a period and a frequency.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STS_READY) |->
      (out_data.period_ticks == '0 && out_data.frequency_q16 == '0))
    else $error("non-measurement result carries a period or frequency");

  // After a transaction is accepted the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again before the previous transaction was processed");

endmodule

[test/tb_input_capture_frequency_meter_top.sv]
// Self-checking testbench for the input capture frequency meter top level.
module tb_input_capture_frequency_meter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icfm_pkg::*;

  // The receiver's long hold-off, in cycles. It is far longer than one measurement, so the
  // block fills its output register, takes one more capture and then stalls its input.
  localparam int HOLD_CYCLES    = 300;
  // Random phases and the number of capture transactions offered in each of them.
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 110;
  // The tail waits longer than one measurement takes from acceptance to result.
  localparam int TAIL_CYCLES    = 64;
  // Slowest correct run: about 900 transactions, each with its input gap, processing and
  // receiver stall, plus the hold-off. The limit allows several times that.
  localparam int LIMIT_NS       = 4_000_000;

  // Scoreboard: it mirrors the meter's pairing state and registers, works out the reading
  // that each accepted capture must produce, and checks the readings as they leave the block.
  class capture_scoreboard;
    logic [BUS_W-1:0] bus_hz;
    logic [PRE_W-1:0] prescale;
    bit               second_capture;
    logic [CAP_W-1:0] first_capture;
    out_item_t        pending_readings[$];
    int               errors;

    function new();
      bus_hz         = BUS_CLOCK_RESET;
      prescale       = PRESCALE_RESET;
      second_capture = 1'b0;
      first_capture  = '0;
      errors         = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_BUS_CLOCK) begin
        bus_hz = value[BUS_W-1:0];
      end else if (idx == CFG_PRESCALE) begin
        prescale = value[PRE_W-1:0];
      end
    endfunction

    // Works out the reading for one capture and advances the pairing state.
    function out_item_t measure_capture(in_item_t cap);
      out_item_t        reading;
      logic [CAP_W-1:0] ticks;
      logic [63:0]      numerator;
      logic [63:0]      divisor;
      logic [63:0]      quotient;
      reading                = '0;
      reading.status         = STS_STORED;
      reading.moving_forward = cap.direction_pin;
      if (!second_capture) begin
        first_capture  = cap.capture_value;
        second_capture = 1'b1;
      end else begin
        second_capture = 1'b0;
        if (cap.capture_value == first_capture) begin
          reading.status = STS_ERROR;
        end else begin
          // The subtraction at counter width absorbs one rollover of the timer.
          ticks     = cap.capture_value - first_capture;
          numerator = 64'(bus_hz) << FRAC_W;
          divisor   = 64'(ticks) * ((prescale == '0) ? 64'd1 : 64'(prescale));
          quotient  = numerator / divisor;
          reading.status        = STS_READY;
          reading.period_ticks  = PER_W'(ticks);
          reading.frequency_q16 = quotient[FREQ_W-1:0];
        end
      end
      return reading;
    endfunction

    function void note_capture(in_item_t cap);
      pending_readings.push_back(measure_capture(cap));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        $error("reading with no capture outstanding: status %0d", got.status);
        return;
      end
      want = pending_readings.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("period_ticks", 64'(want.period_ticks), 64'(got.period_ticks));
      compare_field("frequency_q16", 64'(want.frequency_q16), 64'(got.frequency_q16));
      compare_field("moving_forward", 64'(want.moving_forward), 64'(got.moving_forward));
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  // Shared controls between the stimulus and the receiver: quiet removes all idling on both
  // sides, long_hold asks the receiver for one long stall after its next transaction.
  bit quiet;
  bit long_hold;

  capture_scoreboard sb = new();

  input_capture_frequency_meter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor. Both handshakes are sampled at the rising edge, before any register of the
  // block or of the testbench has taken its new value. A result leaving at this edge always
  // belongs to an earlier capture, so the check comes before the new capture is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if (in_valid && in_ready) begin
        sb.note_capture(in_data);
      end
    end
  end

  // Receiver. Before each transaction it stalls for a random number of cycles, except in a
  // quiet stretch. When asked, it holds off for a long stretch after a transaction so that
  // the block backs up into its input.
  initial begin
    int stall;
    out_ready <= 1'b0;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one capture transaction and returns at the edge that accepts it. Valid is only
  // lowered when a gap follows, so it is never dropped and raised within one time step.
  task automatic offer_capture(input logic [CAP_W-1:0] value, input logic dir);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{capture_value: value, direction_pin: dir};
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every outstanding reading has come back. Every capture
  // gives exactly one reading, so the block is idle once this returns.
  task automatic drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Writes both registers on consecutive edges; only called while the block is idle.
  task automatic program_meter(input logic [CFG_DATA_W-1:0] bus,
                               input logic [CFG_DATA_W-1:0] pre);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BUS_CLOCK;
    cfg_wdata <= bus;
    sb.set_register(CFG_BUS_CLOCK, bus);
    @(posedge clk);
    cfg_index <= CFG_PRESCALE;
    cfg_wdata <= pre;
    sb.set_register(CFG_PRESCALE, pre);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_bus_clock();
    case ($urandom_range(0, 5))
      0:       return 26'd1;
      1:       return 26'd64000000;
      2:       return {BUS_W{1'b1}};
      3:       return 26'd0;
      default: return CFG_DATA_W'($urandom_range(1, 64000000));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_prescale();
    case ($urandom_range(0, 6))
      0:       return 26'd1;
      1:       return 26'd65536;
      2:       return 26'h1FFFF;
      3:       return 26'd0;
      4:       return CFG_DATA_W'($urandom_range(1, 16));
      default: return CFG_DATA_W'($urandom_range(1, 65536));
    endcase
  endfunction

  // One random phase. Each capture is drawn relative to the previous one, so short and long
  // periods, rollovers and equal pairs all turn up, with fully random values mixed in.
  task automatic run_random_phase(input int items);
    logic [CAP_W-1:0] last_value;
    logic [CAP_W-1:0] value;
    last_value = CAP_W'($urandom);
    for (int n = 0; n < items; n++) begin
      case ($urandom_range(0, 9))
        0:       value = last_value;
        1, 2:    value = last_value + CAP_W'($urandom_range(1, 16));
        3:       value = last_value - CAP_W'($urandom_range(1, 16));
        4, 5:    value = CAP_W'($urandom);
        default: value = last_value + CAP_W'($urandom_range(1, 65535));
      endcase
      offer_capture(value, 1'($urandom));
      last_value = value;
    end
  endtask

  // Stimulus and the end of the run.
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_BUS_CLOCK;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    quiet     = 1'b0;
    long_hold = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first under the reset settings: the extreme captures, a rollover of one
    // tick, equal captures and a near-full wrap.
    offer_capture(16'h0000, 1'b1);
    offer_capture(16'hFFFF, 1'b0);
    offer_capture(16'hFFFF, 1'b1);
    offer_capture(16'h0000, 1'b0);
    offer_capture(16'h1234, 1'b1);
    offer_capture(16'h1234, 1'b1);
    offer_capture(16'h8000, 1'b0);
    offer_capture(16'h7FFF, 1'b1);
    drain_readings();

    // Largest bus clock with no prescaling: the largest frequency the output can hold.
    program_meter({BUS_W{1'b1}}, 26'd1);
    offer_capture(16'h0000, 1'b0);
    offer_capture(16'h0001, 1'b1);
    offer_capture(16'h0000, 1'b1);
    offer_capture(16'hFFFF, 1'b0);
    drain_readings();

    // A bus clock of zero gives a frequency of zero; a prescale of zero acts as one.
    program_meter(26'd0, 26'd0);
    offer_capture(16'h0010, 1'b1);
    offer_capture(16'h0020, 1'b0);
    drain_readings();

    // Smallest nonzero bus clock against the widest prescale and the longest period.
    program_meter(26'd1, 26'h1FFFF);
    offer_capture(16'h0000, 1'b0);
    offer_capture(16'hFFFF, 1'b1);
    drain_readings();

    // Prescale data with bits set above the register's width, which must be dropped.
    program_meter(26'd64000000, 26'h3FE0001);
    offer_capture(16'h5555, 1'b1);
    offer_capture(16'hAAAA, 1'b0);
    drain_readings();

    program_meter(26'd64000000, 26'd65536);
    offer_capture(16'hAAAA, 1'b0);
    offer_capture(16'h5555, 1'b1);
    drain_readings();

    // Random phases, each under fresh settings. Between phases the sender waits for every
    // reading to return. One phase carries the long receiver hold-off, another runs with no
    // idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      program_meter(pick_bus_clock(), pick_prescale());
      quiet     = (p == 4);
      long_hold = (p == 2);
      run_random_phase(PHASE_ITEMS);
      drain_readings();
    end
    quiet = 1'b0;

    // Let any stray reading surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_input_capture_frequency_meter_top: done, clean");
    end else begin
      $display("tb_input_capture_frequency_meter_top: done, errors");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #(LIMIT_NS);
    $display("tb_input_capture_frequency_meter_top: done, errors");
    $finish;
  end

endmodule
